[rtl/core/apr_pkg.sv]
// Shared types, constants and helpers for the affine pixel remap engine.
`timescale 1ns / 1ps

package apr_pkg;

    // Frame geometry and store sizing
    localparam int FRAME_WIDTH  = 512;
    localparam int FRAME_HEIGHT = 512;
    localparam int STORE_DEPTH  = 262144;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);

    // Field widths
    localparam int POS_W      = 9;
    localparam int PIX_W      = 32;
    localparam int COEF_W     = 19;
    localparam int OFFS_W     = 30;
    localparam int MULT_W     = COEF_W + POS_W + 1;
    localparam int SUM_W      = 32;
    localparam int FRAC_W     = 16;
    localparam int COORD_W    = SUM_W - FRAC_W;
    localparam int ENTRY_W    = ADDR_W + 1;
    localparam int REG_IDX_W  = 3;
    localparam int CFG_DATA_W = 30;

    // Q16 rounding: add one half, then truncate toward zero
    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1 << (FRAC_W - 1));
    localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'((1 << FRAC_W) - 1);

    // Command queue between front and back (power of two)
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);

    typedef enum logic [1:0] {
        ACT_STORE = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_MAP   = 2'd2,
        ACT_EMIT  = 2'd3
    } action_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_COEF_XX  = 3'd0,
        REG_COEF_XY  = 3'd1,
        REG_OFFSET_X = 3'd2,
        REG_COEF_YX  = 3'd3,
        REG_COEF_YY  = 3'd4,
        REG_OFFSET_Y = 3'd5,
        REG_MODE     = 3'd6
    } reg_index_t;

    typedef enum logic [1:0] {
        CMD_PIX_WR   = 2'd0,
        CMD_MAP_WR   = 2'd1,
        CMD_EMIT     = 2'd2,
        CMD_EMIT_OFF = 2'd3
    } cmd_op_t;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_MAP  = 2'd1,
        BK_PIX  = 2'd2
    } back_state_t;

    typedef struct packed {
        action_t            action;
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
        logic [PIX_W-1:0]   pixel_value;
    } pixel_in_t;

    typedef struct packed {
        logic [PIX_W-1:0]   out_pixel;
        logic               was_mapped;
    } pixel_out_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_xx;
        logic signed [COEF_W-1:0] coef_xy;
        logic signed [OFFS_W-1:0] offset_x;
        logic signed [COEF_W-1:0] coef_yx;
        logic signed [COEF_W-1:0] coef_yy;
        logic signed [OFFS_W-1:0] offset_y;
        logic                     inverse;
        logic                     black;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        coef_xx:  COEF_W'(65536),
        coef_xy:  '0,
        offset_x: '0,
        coef_yx:  '0,
        coef_yy:  COEF_W'(65536),
        offset_y: '0,
        inverse:  1'b0,
        black:    1'b0
    };

    typedef struct packed {
        cmd_op_t            op;
        logic [ADDR_W-1:0]  addr;
        logic [PIX_W-1:0]   data;
        logic               black;
    } cmd_t;

    typedef struct packed {
        logic               ok;
        logic [ADDR_W-1:0]  idx;
    } lin_t;

    // Linear store index of (x,y); ok is low when off frame or past the store
    function automatic lin_t lin_index(input logic signed [COORD_W-1:0] x,
                                       input logic signed [COORD_W-1:0] y);
        lin_t        r;
        logic [31:0] full;
        full  = 32'($unsigned(y)) * 32'(FRAME_WIDTH) + 32'($unsigned(x));
        r.ok  = (x >= 0) && (y >= 0) && (x < FRAME_WIDTH) && (y < FRAME_HEIGHT)
                && (full < 32'(STORE_DEPTH));
        r.idx = full[ADDR_W-1:0];
        return r;
    endfunction

endpackage

[rtl/core/apr_front.sv]
// Front end: accepts transactions, runs the affine transform, builds back-end commands.
`timescale 1ns / 1ps

module apr_front (
    input  logic               clk,
    input  logic               rst_n,
    input  apr_pkg::pixel_in_t item,
    input  logic               item_valid,
    output logic               item_ready,
    input  apr_pkg::cfg_t      cfg,
    output apr_pkg::cmd_t      cmd,
    output logic               cmd_push,
    input  logic               cmd_full
);
    import apr_pkg::*;

    // stage 1: products and source index
    logic                       s1_valid_reg;
    action_t                    s1_action_reg;
    logic [PIX_W-1:0]           s1_pix_reg;
    lin_t                       s1_p_reg;
    logic signed [MULT_W-1:0]   m_xx_reg, m_xy_reg, m_yx_reg, m_yy_reg;

    // stage 2: Q16 sums
    logic                       s2_valid_reg;
    action_t                    s2_action_reg;
    logic [PIX_W-1:0]           s2_pix_reg;
    lin_t                       s2_p_reg;
    logic signed [SUM_W-1:0]    sum_x_reg, sum_y_reg;

    // stage 3: integer target coordinates
    logic                       s3_valid_reg;
    action_t                    s3_action_reg;
    logic [PIX_W-1:0]           s3_pix_reg;
    lin_t                       s3_p_reg;
    logic signed [COORD_W-1:0]  nx_reg, ny_reg;

    logic                       adv1, adv2, adv3, keep;
    lin_t                       p_in, q;
    logic signed [POS_W:0]      x_s, y_s;
    logic signed [SUM_W-1:0]    tx, ty;

    assign x_s  = $signed({1'b0, item.pos_x});
    assign y_s  = $signed({1'b0, item.pos_y});
    assign p_in = lin_index(COORD_W'(item.pos_x), COORD_W'(item.pos_y));

    assign adv3       = !s3_valid_reg || !keep || !cmd_full;
    assign adv2       = !s2_valid_reg || adv3;
    assign adv1       = !s1_valid_reg || adv2;
    assign item_ready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                s1_valid_reg <= item_valid;
            if (adv2)
                s2_valid_reg <= s1_valid_reg;
            if (adv3)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && item_valid)
        begin
            s1_action_reg <= item.action;
            s1_pix_reg    <= item.pixel_value;
            s1_p_reg      <= p_in;
            m_xx_reg      <= cfg.coef_xx * x_s;
            m_xy_reg      <= cfg.coef_xy * y_s;
            m_yx_reg      <= cfg.coef_yx * x_s;
            m_yy_reg      <= cfg.coef_yy * y_s;
        end
        if (adv2 && s1_valid_reg)
        begin
            s2_action_reg <= s1_action_reg;
            s2_pix_reg    <= s1_pix_reg;
            s2_p_reg      <= s1_p_reg;
            sum_x_reg     <= SUM_W'(m_xx_reg) + SUM_W'(m_xy_reg)
                             + SUM_W'(cfg.offset_x) + ROUND_HALF;
            sum_y_reg     <= SUM_W'(m_yx_reg) + SUM_W'(m_yy_reg)
                             + SUM_W'(cfg.offset_y) + ROUND_HALF;
        end
        if (adv3 && s2_valid_reg)
        begin
            s3_action_reg <= s2_action_reg;
            s3_pix_reg    <= s2_pix_reg;
            s3_p_reg      <= s2_p_reg;
            nx_reg        <= tx[SUM_W-1:FRAC_W];
            ny_reg        <= ty[SUM_W-1:FRAC_W];
        end
    end

    // truncate toward zero: bias negative sums before the arithmetic shift
    assign tx = sum_x_reg + (sum_x_reg[SUM_W-1] ? ROUND_BIAS : '0);
    assign ty = sum_y_reg + (sum_y_reg[SUM_W-1] ? ROUND_BIAS : '0);

    assign q = lin_index(nx_reg, ny_reg);

    always_comb
    begin
        keep      = 1'b0;
        cmd.op    = CMD_PIX_WR;
        cmd.addr  = s3_p_reg.idx;
        cmd.data  = s3_pix_reg;
        cmd.black = cfg.black;
        case (s3_action_reg)
            ACT_STORE:
            begin
                keep = s3_p_reg.ok;
            end
            ACT_CLEAR:
            begin
                keep     = s3_p_reg.ok;
                cmd.op   = CMD_MAP_WR;
                cmd.data = '0;
            end
            ACT_MAP:
            begin
                keep   = s3_p_reg.ok && q.ok;
                cmd.op = CMD_MAP_WR;
                if (cfg.inverse)
                    cmd.data = PIX_W'({1'b1, q.idx});
                else
                begin
                    cmd.addr = q.idx;
                    cmd.data = PIX_W'({1'b1, s3_p_reg.idx});
                end
            end
            ACT_EMIT:
            begin
                keep   = 1'b1;
                cmd.op = s3_p_reg.ok ? CMD_EMIT : CMD_EMIT_OFF;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign cmd_push = s3_valid_reg && keep && !cmd_full;

endmodule

[rtl/core/apr_cmd_fifo.sv]
// Small command queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module apr_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  apr_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output apr_pkg::cmd_t pop_data,
    output logic          not_empty
);
    import apr_pkg::*;

    cmd_t               mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]     count_reg;

    assign full      = (count_reg == (PTR_W + 1)'(FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

[rtl/core/apr_back.sv]
// Back end: frame store and remap table, executes commands and drives results.
`timescale 1ns / 1ps

module apr_back (
    input  logic                clk,
    input  logic                rst_n,
    input  apr_pkg::cmd_t       cmd,
    input  logic                cmd_valid,
    output logic                cmd_pop,
    output apr_pkg::pixel_out_t result,
    output logic                result_valid,
    input  logic                result_ready
);
    import apr_pkg::*;

    logic [PIX_W-1:0]   frame_mem [STORE_DEPTH];
    logic [ENTRY_W-1:0] map_mem   [STORE_DEPTH];

    back_state_t        state_reg, state_next;
    logic [ENTRY_W-1:0] map_rdata_reg;
    logic [PIX_W-1:0]   pix_rdata_reg;
    logic [ADDR_W-1:0]  emit_addr_reg;
    logic               emit_black_reg, emit_off_reg;
    logic               mapped_reg, zero_reg;
    logic               result_valid_reg, result_valid_next;

    logic               pix_we, map_we, map_re, pix_re;
    logic               load_ctx, load_flags, result_load;
    logic [ADDR_W-1:0]  pix_raddr;
    logic               entry_valid;

    assign entry_valid = map_rdata_reg[ADDR_W];

    always_comb
    begin
        state_next  = state_reg;
        cmd_pop     = 1'b0;
        pix_we      = 1'b0;
        map_we      = 1'b0;
        map_re      = 1'b0;
        pix_re      = 1'b0;
        load_ctx    = 1'b0;
        load_flags  = 1'b0;
        result_load = 1'b0;
        pix_raddr   = emit_addr_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.op)
                        CMD_PIX_WR: pix_we = 1'b1;
                        CMD_MAP_WR: map_we = 1'b1;
                        CMD_EMIT, CMD_EMIT_OFF:
                        begin
                            map_re     = 1'b1;
                            load_ctx   = 1'b1;
                            state_next = BK_MAP;
                        end
                        default: ;
                    endcase
                end
            end
            BK_MAP:
            begin
                // a valid entry redirects the read to its source pixel
                pix_re     = 1'b1;
                load_flags = 1'b1;
                if (entry_valid)
                    pix_raddr = map_rdata_reg[ADDR_W-1:0];
                state_next = BK_PIX;
            end
            BK_PIX:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_load = 1'b1;
                    state_next  = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    assign result_valid_next = result_load || (result_valid_reg && !result_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= BK_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_we)
            frame_mem[cmd.addr] <= cmd.data;
        if (pix_re)
            pix_rdata_reg <= frame_mem[pix_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
            map_mem[cmd.addr] <= cmd.data[ENTRY_W-1:0];
        if (map_re)
            map_rdata_reg <= map_mem[cmd.addr];
    end

    always_ff @(posedge clk)
    begin
        if (load_ctx)
        begin
            emit_addr_reg  <= cmd.addr;
            emit_black_reg <= cmd.black;
            emit_off_reg   <= (cmd.op == CMD_EMIT_OFF);
        end
        if (load_flags)
        begin
            mapped_reg <= !emit_off_reg && entry_valid;
            zero_reg   <= emit_off_reg || (!entry_valid && emit_black_reg);
        end
        if (result_load)
        begin
            result.out_pixel  <= zero_reg ? '0 : pix_rdata_reg;
            result.was_mapped <= mapped_reg;
        end
    end

    assign result_valid = result_valid_reg;

endmodule

[rtl/core/affine_pixel_remap.sv]
// Top level of the affine pixel remap engine.
`timescale 1ns / 1ps

// Affine pixel remap engine. Each input transaction stores a pixel, clears a
// remap entry, maps a position through a 2x3 Q16 affine transform (rounded by
// adding one half and truncating toward zero, then range checked against the
// frame) or emits one output pixel; only emit returns a result transaction.
// Forward mode writes the source index into the entry at the target, inverse
// mode the target index into the entry at the source. The front end is a
// three-stage pipeline (multiply, sum, round) that takes one transaction per
// clock while the four-deep command queue it feeds has room. The back end owns
// the frame store and the remap table, one single-port memory each: stores,
// clears and maps retire at one per clock there; an emit holds the back end
// until its result is loaded, as it needs two dependent memory reads (table
// entry, then pixel). Sustained rate is one transaction per clock without
// emits. An emit result is registered after the front stages, the queue, the
// MAP and PIX states. The memories are not cleared: an entry must be written
// before it is read. The user must write configuration through the cfg port
// (always ready) only while no transaction is in flight; this is not enforced.
module affine_pixel_remap (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  apr_pkg::pixel_in_t                  item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output apr_pkg::pixel_out_t                 result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [apr_pkg::REG_IDX_W-1:0]       cfg_index,
    input  logic [apr_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import apr_pkg::*;

    cfg_t   cfg_reg, cfg_next;
    cmd_t   push_cmd, pop_cmd;
    logic   cmd_push, cmd_full, cmd_pop, cmd_valid;

    // register file: index picks the field, upper data bits are dropped
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_COEF_XX:  cfg_next.coef_xx  = cfg_data[COEF_W-1:0];
                REG_COEF_XY:  cfg_next.coef_xy  = cfg_data[COEF_W-1:0];
                REG_OFFSET_X: cfg_next.offset_x = cfg_data[OFFS_W-1:0];
                REG_COEF_YX:  cfg_next.coef_yx  = cfg_data[COEF_W-1:0];
                REG_COEF_YY:  cfg_next.coef_yy  = cfg_data[COEF_W-1:0];
                REG_OFFSET_Y: cfg_next.offset_y = cfg_data[OFFS_W-1:0];
                REG_MODE:
                begin
                    cfg_next.inverse = cfg_data[0];
                    cfg_next.black   = cfg_data[1];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

    // front: accept, transform, classify
    apr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .cfg        (cfg_reg),
        .cmd        (push_cmd),
        .cmd_push   (cmd_push),
        .cmd_full   (cmd_full)
    );

    // queue lets either side stall alone
    apr_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (cmd_push),
        .push_data  (push_cmd),
        .full       (cmd_full),
        .pop        (cmd_pop),
        .pop_data   (pop_cmd),
        .not_empty  (cmd_valid)
    );

    // back: memories and result register
    apr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (pop_cmd),
        .cmd_valid    (cmd_valid),
        .cmd_pop      (cmd_pop),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

endmodule

[rtl/core/apr_checker.sv]
// Port-level checks on the remap engine, bound to the top level.
`timescale 1ns / 1ps

module apr_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 item_ready,
    input logic                 result_valid,
    input logic                 result_ready,
    input apr_pkg::pixel_out_t  result
);

    // no result while held in reset
    a_no_result_in_reset: assert property (@(posedge clk) !rst_n |-> !result_valid)
        else $error("result valid during reset");

    // pipeline is empty right after reset, so input is ready
    a_ready_after_reset: assert property (@(posedge clk) $past(!rst_n) |-> item_ready)
        else $error("input not ready right after reset");

    // emit needs the full front pipeline and two memory reads
    a_min_latency: assert property (@(posedge clk) $past(!rst_n, 4) |-> !result_valid)
        else $error("result too soon after reset");

    // a stalled result holds its value
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("stalled result changed");

endmodule

bind affine_pixel_remap apr_checker u_apr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

[bench/affine_pixel_remap_tb.sv]
// Self-checking testbench for the affine pixel remap engine.
`timescale 1ns / 1ps

module affine_pixel_remap_tb;

    import apr_pkg::*;

    // Cycles to let in-flight stores, clears and maps retire once the last
    // emit result is back. That covers the 3-stage front end, the 4-deep
    // command queue and any emits still waiting in it, with margin.
    localparam int DRAIN_CYCLES = 24;
    // Long receiver hold-off used to back the engine up to its input
    localparam int HOLD_CYCLES  = 120;
    // Upper bound on the wait for outstanding results at the end of the run
    localparam int FINAL_WAIT   = 50000;
    // Remap entry layout: valid flag above the linear index
    localparam int ENTRY_VALID  = ADDR_W;
    // Side of the square working window that most random traffic hits
    localparam int WIN          = 3;

    // Transform and mode currently loaded in the engine
    typedef struct packed {
        longint coef_xx;
        longint coef_xy;
        longint offset_x;
        longint coef_yx;
        longint coef_yy;
        longint offset_y;
        bit     inverse;
        bit     black;
    } warp_t;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_ready;
    pixel_in_t   item;
    logic        result_valid;
    logic        result_ready;
    pixel_out_t  result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [REG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Shadow copies of the frame store and remap table. Only entries the
    // engine has actually written exist here; emits are only generated when
    // every entry they read has been written.
    logic [PIX_W-1:0]   pixel_mem [int];
    logic [ENTRY_W-1:0] remap_mem [int];
    int                 written_entries[$];

    warp_t       warp;
    pixel_out_t  pending_pixels[$];     // emit results still owed by the engine
    int          mismatch_count;
    int          burst_left;            // transactions left in the current burst
    bit          hold_request;          // asks the receiver for a long hold-off
    int          win_x;
    int          win_y;

    affine_pixel_remap DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic warp_t build_warp(input longint xx, input longint xy,
                                         input longint ox, input longint yx,
                                         input longint yy, input longint oy,
                                         input bit inverse, input bit black);
        warp_t w;
        w.coef_xx  = xx;
        w.coef_xy  = xy;
        w.offset_x = ox;
        w.coef_yx  = yx;
        w.coef_yy  = yy;
        w.offset_y = oy;
        w.inverse  = inverse;
        w.black    = black;
        return w;
    endfunction

    // Linear store index, or -1 when off the frame or past the store
    function automatic int frame_index(input longint x, input longint y);
        longint lin;
        if (x < 0 || y < 0 || x >= FRAME_WIDTH || y >= FRAME_HEIGHT)
            return -1;
        lin = y * FRAME_WIDTH + x;
        if (lin >= STORE_DEPTH)
            return -1;
        return int'(lin);
    endfunction

    // Q16 transform: add one half, then divide with truncation toward zero,
    // so sums in (-1,0) land on column/row zero rather than off the frame.
    function automatic int warp_target(input int x, input int y);
        longint sum_x;
        longint sum_y;
        sum_x = warp.coef_xx * x + warp.coef_xy * y + warp.offset_x + 32768;
        sum_y = warp.coef_yx * x + warp.coef_yy * y + warp.offset_y + 32768;
        return frame_index(sum_x / 65536, sum_y / 65536);
    endfunction

    function automatic void record_entry(input int idx, input logic [ENTRY_W-1:0] ent);
        if (!remap_mem.exists(idx))
            written_entries.push_back(idx);
        remap_mem[idx] = ent;
    endfunction

    // True when an emit at (x,y) reads only entries that were written
    function automatic bit emit_allowed(input int x, input int y);
        int               idx;
        logic [ENTRY_W-1:0] ent;
        idx = frame_index(x, y);
        if (idx < 0)
            return 1'b1;
        if (!remap_mem.exists(idx))
            return 1'b0;
        ent = remap_mem[idx];
        if (ent[ENTRY_VALID])
            return pixel_mem.exists(int'(ent[ADDR_W-1:0]));
        return pixel_mem.exists(idx);
    endfunction

    // Update the shadow state for one accepted transaction and queue the
    // result an emit owes.
    function automatic void apply_action(input pixel_in_t it);
        int                 x;
        int                 y;
        int                 src;
        int                 dst;
        logic [ENTRY_W-1:0] ent;
        pixel_out_t         want;
        x   = it.pos_x;
        y   = it.pos_y;
        src = frame_index(x, y);
        case (it.action)
            ACT_STORE:
            begin
                if (src >= 0)
                    pixel_mem[src] = it.pixel_value;
            end
            ACT_CLEAR:
            begin
                if (src >= 0)
                    record_entry(src, '0);
            end
            ACT_MAP:
            begin
                dst = (src >= 0) ? warp_target(x, y) : -1;
                if (dst >= 0)
                begin
                    // Forward: entry at the target names the source.
                    // Inverse: entry at the source names the target.
                    if (!warp.inverse)
                        record_entry(dst, {1'b1, ADDR_W'(src)});
                    else
                        record_entry(src, {1'b1, ADDR_W'(dst)});
                end
            end
            default:
            begin
                want.out_pixel  = '0;
                want.was_mapped = 1'b0;
                if (src >= 0)
                begin
                    ent = remap_mem.exists(src) ? remap_mem[src] : '0;
                    if (ent[ENTRY_VALID])
                    begin
                        dst             = int'(ent[ADDR_W-1:0]);
                        want.out_pixel  = pixel_mem.exists(dst) ? pixel_mem[dst] : '0;
                        want.was_mapped = 1'b1;
                    end
                    else if (!warp.black && pixel_mem.exists(src))
                        want.out_pixel = pixel_mem[src];
                end
                pending_pixels.push_back(want);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string text);
        $display("%0t ERROR: %s", $time, text);
        mismatch_count++;
    endtask

    task automatic compare_pixel(input pixel_out_t got);
        pixel_out_t want;
        if (pending_pixels.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result pixel=%h mapped=%b",
                                      got.out_pixel, got.was_mapped));
            return;
        end
        want = pending_pixels.pop_front();
        if (got.out_pixel !== want.out_pixel)
            report_mismatch($sformatf("out_pixel got %h want %h",
                                      got.out_pixel, want.out_pixel));
        if (got.was_mapped !== want.was_mapped)
            report_mismatch($sformatf("was_mapped got %b want %b",
                                      got.was_mapped, want.was_mapped));
    endtask

    // Receiver: checks every accepted result, and stalls in segments of
    // random length with a per-segment stall rate (zero in some segments).
    // A hold request from the stimulus side drops ready for HOLD_CYCLES.
    initial
    begin
        int seg_left;
        int stall_pct;
        int hold_left;
        seg_left  = 0;
        stall_pct = 0;
        hold_left = 0;
        result_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_valid && result_ready)
                compare_pixel(result);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(16, 96);
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 20;
                    2:       stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            seg_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus side
    // ------------------------------------------------------------------

    function automatic pixel_in_t make_item(input action_t act, input int x, input int y,
                                            input logic [PIX_W-1:0] value);
        pixel_in_t it;
        it.action      = act;
        it.pos_x       = POS_W'(x);
        it.pos_y       = POS_W'(y);
        it.pixel_value = value;
        return it;
    endfunction

    // Sends one transaction. Bursts of random length are separated by
    // short gaps; valid stays high across back-to-back transactions.
    task automatic send_item(input pixel_in_t it);
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 8);
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        burst_left--;
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        apply_action(it);
    endtask

    // Stop offering, wait for every owed result, then let the back end
    // retire whatever writes are still queued behind the last emit.
    task automatic wait_for_idle();
        item_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Leaves cfg_valid high so consecutive writes run back to back.
    task automatic write_reg(input reg_index_t idx, input longint value);
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic set_config(input warp_t w);
        wait_for_idle();
        write_reg(REG_COEF_XX,  w.coef_xx);
        write_reg(REG_COEF_XY,  w.coef_xy);
        write_reg(REG_OFFSET_X, w.offset_x);
        write_reg(REG_COEF_YX,  w.coef_yx);
        write_reg(REG_COEF_YY,  w.coef_yy);
        write_reg(REG_OFFSET_Y, w.offset_y);
        write_reg(REG_MODE,     longint'({w.black, w.inverse}));
        cfg_valid <= 1'b0;
        warp = w;
    endtask

    function automatic void pick_pos(output int x, output int y);
        if ($urandom_range(0, 3) != 0)
        begin
            x = win_x + $urandom_range(0, WIN - 1);
            y = win_y + $urandom_range(0, WIN - 1);
        end
        else
        begin
            x = $urandom_range(0, FRAME_WIDTH - 1);
            y = $urandom_range(0, FRAME_HEIGHT - 1);
        end
    endfunction

    task automatic pick_window();
        win_x = $urandom_range(0, FRAME_WIDTH - WIN);
        win_y = $urandom_range(0, FRAME_HEIGHT - WIN);
    endtask

    // Random transform with coefficients up to +/-2.0, with offsets that
    // pull the window center roughly onto the frame so most maps land.
    function automatic warp_t random_warp(input bit inverse, input bit black);
        longint xx;
        longint xy;
        longint yx;
        longint yy;
        longint ox;
        longint oy;
        xx = longint'($urandom_range(0, 262144)) - 131072;
        xy = longint'($urandom_range(0, 262144)) - 131072;
        yx = longint'($urandom_range(0, 262144)) - 131072;
        yy = longint'($urandom_range(0, 262144)) - 131072;
        ox = longint'($urandom_range(32, 480)) * 65536 - xx * (win_x + 1) - xy * (win_y + 1)
             + longint'($urandom_range(0, 65535)) - 32768;
        oy = longint'($urandom_range(32, 480)) * 65536 - yx * (win_x + 1) - yy * (win_y + 1)
             + longint'($urandom_range(0, 65535)) - 32768;
        return build_warp(xx, xy, ox, yx, yy, oy, inverse, black);
    endfunction

    // Well-formed setup for a window: clear, store and map each position,
    // then store a pixel at every target so emits can go either way.
    task automatic prime_window();
        int i;
        int x;
        int y;
        int dst;
        for (i = 0; i < WIN * WIN; i++)
        begin
            x = win_x + i % WIN;
            y = win_y + i / WIN;
            send_item(make_item(ACT_CLEAR, x, y, $urandom()));
            send_item(make_item(ACT_STORE, x, y, $urandom()));
            send_item(make_item(ACT_MAP, x, y, $urandom()));
        end
        for (i = 0; i < WIN * WIN; i++)
        begin
            dst = warp_target(win_x + i % WIN, win_y + i / WIN);
            if (dst >= 0)
                send_item(make_item(ACT_STORE, dst % FRAME_WIDTH, dst / FRAME_WIDTH,
                                    $urandom()));
        end
    endtask

    // One random transaction. An emit is only sent where every entry it
    // reads is defined; when no such spot turns up, a store goes instead.
    task automatic send_random(input int emit_pct);
        int  x;
        int  y;
        int  idx;
        int  roll;
        int  tries;
        bit  found;
        roll = $urandom_range(0, 99);
        pick_pos(x, y);
        if (roll < emit_pct)
        begin
            found = emit_allowed(x, y);
            for (tries = 0; tries < 8 && !found; tries++)
            begin
                if ($urandom_range(0, 1) == 1 && written_entries.size() > 0)
                begin
                    idx = written_entries[$urandom_range(0, written_entries.size() - 1)];
                    x   = idx % FRAME_WIDTH;
                    y   = idx / FRAME_WIDTH;
                end
                else
                    pick_pos(x, y);
                found = emit_allowed(x, y);
            end
            send_item(make_item(found ? ACT_EMIT : ACT_STORE, x, y, $urandom()));
        end
        else
        begin
            roll = $urandom_range(0, 9);
            send_item(make_item(roll < 4 ? ACT_STORE : (roll < 8 ? ACT_MAP : ACT_CLEAR),
                                x, y, $urandom()));
        end
    endtask

    task automatic run_warp_phase(input warp_t w, input int count, input int emit_pct);
        set_config(w);
        prime_window();
        repeat (count) send_random(emit_pct);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every action at the frame corners with the reset transform
    // (identity, forward, no black fill) and extreme pixel values.
    task automatic test_directed_actions();
        send_item(make_item(ACT_STORE, 0, 0, 32'hFFFF_FFFF));
        send_item(make_item(ACT_STORE, 511, 511, 32'h0000_0000));
        send_item(make_item(ACT_STORE, 511, 0, 32'hA5A5_A5A5));
        send_item(make_item(ACT_STORE, 0, 511, 32'h5A5A_5A5A));
        send_item(make_item(ACT_CLEAR, 511, 511, 32'h0000_0000));
        send_item(make_item(ACT_EMIT, 511, 511, 32'hFFFF_FFFF));  // unmapped
        send_item(make_item(ACT_MAP, 0, 0, 32'h0));
        send_item(make_item(ACT_EMIT, 0, 0, 32'h0));              // through entry
        send_item(make_item(ACT_MAP, 511, 0, 32'h0));
        send_item(make_item(ACT_EMIT, 511, 0, 32'h0));
        send_item(make_item(ACT_CLEAR, 0, 0, 32'h0));
        send_item(make_item(ACT_EMIT, 0, 0, 32'h0));              // cleared again
    endtask

    // Rounding corners with constant transforms: a sum just below zero
    // truncates to column 0, a sum of exactly -1.0 goes off the frame,
    // and exact halves round up.
    task automatic test_rounding_edges();
        set_config(build_warp(0, 0, -65536, 0, 0, 511 * 65536, 1'b1, 1'b1));
        send_item(make_item(ACT_MAP, 511, 0, 32'h0));      // inverse, target (0,511)
        send_item(make_item(ACT_EMIT, 511, 0, 32'h0));
        send_item(make_item(ACT_EMIT, 511, 511, 32'h0));   // unmapped, black fill
        set_config(build_warp(0, 0, -98304, 0, 0, 0, 1'b0, 1'b0));
        send_item(make_item(ACT_CLEAR, 0, 511, 32'h0));
        send_item(make_item(ACT_MAP, 0, 511, 32'h0));      // lands at x = -1: no write
        send_item(make_item(ACT_EMIT, 0, 511, 32'h0));
        set_config(build_warp(0, 0, 32767, 0, 0, 32768, 1'b0, 1'b0));
        send_item(make_item(ACT_MAP, 0, 0, 32'h0));        // lands at (0,1)
        send_item(make_item(ACT_EMIT, 0, 1, 32'h0));
    endtask

    task automatic test_forward_warp();
        pick_window();
        run_warp_phase(random_warp(1'b0, 1'b0), 50, 35);
    endtask

    task automatic test_inverse_warp();
        pick_window();
        run_warp_phase(random_warp(1'b1, 1'b0), 50, 35);
    endtask

    // Coefficients at +/-2.0 and offsets at +/-4096 pixels. The first
    // setting only lands the diagonal on the origin, the second sends
    // every map off the frame.
    task automatic test_extreme_coefficients();
        win_x = $urandom_range(0, FRAME_WIDTH - WIN);
        win_y = win_x;
        run_warp_phase(build_warp(131072, -131072, 0, -131072, 131072, 0, 1'b0, 1'b1),
                       20, 40);
        pick_window();
        run_warp_phase(build_warp(-131072, 131072, 268435456, 131072, -131072,
                                  -268435456, 1'b1, 1'b0), 20, 40);
    endtask

    task automatic test_inverse_black_fill();
        pick_window();
        run_warp_phase(random_warp(1'b1, 1'b1), 50, 35);
    endtask

    // Receiver holds off while the sender keeps offering emit-heavy
    // traffic back to back, so the engine backs up to its input.
    task automatic test_backpressure();
        pick_window();
        run_warp_phase(random_warp(1'b0, 1'b0), 0, 0);
        hold_request = 1'b1;
        burst_left   = 1000;
        repeat (40) send_random(80);
        burst_left   = 0;
    endtask

    initial
    begin
        int waited;
        rst_n        <= 1'b0;
        item_valid   <= 1'b0;
        item         <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= REG_COEF_XX;
        cfg_data     <= '0;
        mismatch_count = 0;
        burst_left     = 0;
        hold_request   = 1'b0;
        win_x          = 0;
        win_y          = 0;
        warp = build_warp(65536, 0, 0, 0, 65536, 0, 1'b0, 1'b0);   // reset values

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_actions();
        test_rounding_edges();
        test_forward_warp();
        test_inverse_warp();
        test_extreme_coefficients();
        test_inverse_black_fill();
        test_backpressure();

        // Wind down: nothing more offered, collect what is still owed.
        item_valid <= 1'b0;
        waited = 0;
        while (pending_pixels.size() != 0 && waited < FINAL_WAIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_pixels.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_pixels.size()));

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[files.f]
rtl/core/apr_pkg.sv
rtl/core/apr_front.sv
rtl/core/apr_cmd_fifo.sv
rtl/core/apr_back.sv
rtl/core/affine_pixel_remap.sv
rtl/core/apr_checker.sv
bench/affine_pixel_remap_tb.sv
